// File: sv/base64_stream_codec_macros.svh
// ----------------------------------------------------------------------------
// base64_stream_codec_macros
// Assertion helpers used by the codec top level, base64_stream_codec.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define B64_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("codec check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define B64_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("codec check failed");

`endif

// File: sv/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, character codes and alphabet functions for the codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Up to four bytes from one input item, entry 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            msg_end;
    } b64_result_t;

    // Six-bit value to alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26)
            c = CHAR_UPPER_A + w;
        else if (v < 6'd52)
            c = CHAR_LOWER_A + w - 8'd26;
        else if (v < SEXTET_PLUS)
            c = CHAR_DIGIT_0 + w - 8'd52;
        else if (v == SEXTET_PLUS)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

    // Character to six-bit value; bit 6 flags anything outside the alphabet
    function automatic logic [6:0] b64_sextet(input logic [7:0] c);
        logic [6:0] s;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            s = {1'b0, 6'(c - CHAR_UPPER_A)};
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            s = {1'b0, 6'(c - CHAR_LOWER_A + 8'd26)};
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            s = {1'b0, 6'(c - CHAR_DIGIT_0 + 8'd52)};
        else if (c == CHAR_PLUS)
            s = {1'b0, SEXTET_PLUS};
        else if (c == CHAR_SLASH)
            s = {1'b0, SEXTET_SLASH};
        else
            s = 7'h40;
        return s;
    endfunction

endpackage

// File: sv/b64_group.sv
// ----------------------------------------------------------------------------
// b64_group
// Mode register, pending group state and per-item result generation.
// ----------------------------------------------------------------------------
module b64_group
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_mode,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        has_data,
    input  logic        msg_end,
    output b64_result_t res
);

    logic        mode_reg;
    logic [23:0] bits_reg,    bits_next;
    logic [1:0]  count_reg,   count_next;
    logic        stopped_reg, stopped_next;

    logic [23:0] gb;
    logic [6:0]  sx;

    always_comb
    begin
        gb           = bits_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        sx           = b64_sextet(in_byte);
        res.bytes    = '0;
        res.count    = 3'd0;
        res.msg_end  = msg_end;

        if (mode_reg == MODE_ENCODE)
        begin
            if (has_data)
            begin
                case (count_reg)
                    2'd0:    gb[23:16] = in_byte;
                    2'd1:    gb[15:8]  = in_byte;
                    2'd2:    gb[7:0]   = in_byte;
                    default: gb = bits_reg;
                endcase
                if (count_reg == 2'd2)
                begin
                    res.bytes[0] = b64_char(gb[23:18]);
                    res.bytes[1] = b64_char(gb[17:12]);
                    res.bytes[2] = b64_char(gb[11:6]);
                    res.bytes[3] = b64_char(gb[5:0]);
                    res.count    = 3'd4;
                    gb           = '0;
                    count_next   = 2'd0;
                end
                else
                begin
                    count_next = count_reg + 2'd1;
                end
            end
            // flush a partial group with padding
            if (msg_end && count_next != 2'd0)
            begin
                res.bytes[0] = b64_char(gb[23:18]);
                res.bytes[1] = b64_char(gb[17:12]);
                res.bytes[2] = (count_next == 2'd2) ? b64_char(gb[11:6]) : CHAR_PAD;
                res.bytes[3] = CHAR_PAD;
                res.count    = 3'd4;
            end
        end
        else
        begin
            if (has_data && !stopped_reg)
            begin
                if (sx[6])
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    case (count_reg)
                        2'd0:    gb[23:18] = sx[5:0];
                        2'd1:    gb[17:12] = sx[5:0];
                        2'd2:    gb[11:6]  = sx[5:0];
                        default: gb[5:0]   = sx[5:0];
                    endcase
                    if (count_reg == 2'd3)
                    begin
                        res.bytes[0] = gb[23:16];
                        res.bytes[1] = gb[15:8];
                        res.bytes[2] = gb[7:0];
                        res.count    = 3'd3;
                        gb           = '0;
                        count_next   = 2'd0;
                    end
                    else
                    begin
                        count_next = count_reg + 2'd1;
                    end
                end
            end
            // partial group of i characters gives i-1 bytes
            if (msg_end && count_next > 2'd1)
            begin
                res.bytes[0] = gb[23:16];
                res.bytes[1] = gb[15:8];
                res.count    = {1'b0, count_next} - 3'd1;
            end
        end

        bits_next = gb;
        if (msg_end)
        begin
            bits_next    = '0;
            count_next   = 2'd0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ENCODE;
            bits_reg    <= '0;
            count_reg   <= 2'd0;
            stopped_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg    <= cfg_mode;
            bits_reg    <= '0;
            count_reg   <= 2'd0;
            stopped_reg <= 1'b0;
        end
        else if (step)
        begin
            bits_reg    <= bits_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: sv/b64_emit.sv
// ----------------------------------------------------------------------------
// b64_emit
// Result register: holds one item's results and shifts them out in order.
// ----------------------------------------------------------------------------
module b64_emit
    import b64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  b64_result_t res,
    output logic        space,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        message_last
);

    logic [3:0][7:0] bytes_reg, bytes_next;
    logic [2:0]      left_reg,  left_next;
    logic            end_reg,   end_next;
    logic            take;

    assign out_valid    = (left_reg != 3'd0);
    assign out_byte     = bytes_reg[0];
    assign run_last     = (left_reg == 3'd1);
    assign message_last = run_last && end_reg;
    assign take         = out_valid && out_ready;
    // free now, or the last result leaves this cycle
    assign space        = (left_reg == 3'd0) || (run_last && out_ready);

    always_comb
    begin
        bytes_next = bytes_reg;
        left_next  = left_reg;
        end_next   = end_reg;
        if (take)
        begin
            bytes_next = {8'h00, bytes_reg[3:1]};
            left_next  = left_reg - 3'd1;
        end
        if (load)
        begin
            bytes_next = res.bytes;
            left_next  = res.count;
            end_next   = res.msg_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 3'd0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        end_reg   <= end_next;
    end

endmodule

// File: sv/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec - streaming base64 encoder/decoder, one mode register
// Latency: an item's first result is valid the cycle after it is accepted.
// Throughput: one item per cycle when it gives no result and none is waiting;
// else one per result while out_ready is high, 1 to 4 results per item.
// Reset: rst_n async low; encode mode, group empty, result register empty.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_macros.svh"

module base64_stream_codec
    import b64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration: decode_mode
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input items
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       has_data,
    input  logic       msg_end,
    // result items
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_last
);

    b64_result_t res;
    logic        space;
    logic        in_take;
    logic        cfg_we;

    // Writes must arrive only while idle, which the block does not enforce; the
    // port is always open. A write empties the pending group and holds off input.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // With no mode write, an item is taken when the result register is empty or
    // its last result leaves this cycle; the group state updates on the same edge.
    assign in_ready = space && !cfg_we;
    assign in_take  = in_valid && in_ready;

    b64_group u_group (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_mode (cfg_data),
        .step     (in_take),
        .in_byte  (in_byte),
        .has_data (has_data),
        .msg_end  (msg_end),
        .res      (res)
    );

    // Items with no result (partial groups, bare markers) skip the load.
    b64_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (in_take && (res.count != 3'd0)),
        .res          (res),
        .space        (space),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_last (message_last)
    );

    // A new item must never overwrite results still waiting
    `B64_ASSERT_NOW(a_no_overwrite, in_valid && in_ready, !out_valid || (run_last && out_ready))
    // Taking a non-final result leaves the rest of the run pending
    `B64_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid)
    // Message end only flags the last result of a run
    `B64_ASSERT_NOW(a_msg_last_in_run, out_valid && message_last, run_last)

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming base64 codec. A scripted list of
// items, mode writes and drain points feeds a clocked driver. A clocked
// monitor keeps its own model of the encoder and decoder, queues the
// characters or bytes that each accepted item must give, and checks every
// result on the output channel against them.
// ----------------------------------------------------------------------------
module tb_top;
    import b64_pkg::*;

    localparam int IDLE_PCT      = 24;    // chance in a hundred that a side idles
    localparam int SETTLE_CYCLES = 4;     // quiet cycles before a mode write or drain point
    localparam int END_SETTLE    = 8;     // quiet cycles before the verdict
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
    localparam int CALM_FIRST    = 200;   // first script step run with no idling
    localparam int CALM_LAST     = 320;
    localparam int TARGET_ITEMS  = 470;
    localparam int REPORT_CAP    = 100;

    // Alphabet, first character in the top byte
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef enum logic [1:0] {STEP_ITEM, STEP_MODE, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t kind;
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       mode;
    } script_step_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       step_end;
        logic       msg_fin;
    } codec_out_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic       cfg_data     = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte      = 8'h00;
    logic       has_data     = 1'b0;
    logic       msg_end      = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_last;

    script_step_t script[$];
    int           next_step    = 0;
    int           data_items   = 0;
    logic         calm         = 1'b0;
    int           quiet_cycles = 0;
    int           stall_cycles = 0;
    int           mismatches   = 0;

    // Model state: pending group, left aligned, and the mode register
    logic       model_mode   = MODE_ENCODE;
    logic [23:0] acc_bits    = '0;
    int         acc_count    = 0;
    logic       dec_halted   = 1'b0;
    codec_out_t awaited[$];

    base64_stream_codec u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .has_data     (has_data),
        .msg_end      (msg_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_last (message_last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Alphabet lookups
    // ------------------------------------------------------------------
    function automatic logic [7:0] char_of(input logic [5:0] v);
        return ALPHABET[8 * (63 - v) +: 8];
    endfunction

    // 64 for pad and anything else outside the alphabet
    function automatic int sextet_of(input logic [7:0] c);
        int i;
        for (i = 0; i < 64; i++)
            if (char_of(6'(i)) == c)
                return i;
        return 64;
    endfunction

    function automatic void clear_group();
        acc_bits   = '0;
        acc_count  = 0;
        dec_halted = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Codec model: one accepted item in, its results onto the awaited queue
    // ------------------------------------------------------------------
    function automatic void codec_step(input logic [7:0] b, input logic has,
                                       input logic last);
        logic [7:0] outs [0:3];
        codec_out_t r;
        int         n;
        int         k;
        int         s;
        n = 0;
        if (model_mode == MODE_ENCODE)
        begin
            if (has)
            begin
                acc_bits  = acc_bits | (24'(b) << (16 - 8 * acc_count));
                acc_count = acc_count + 1;
                if (acc_count == 3)
                begin
                    for (k = 0; k < 4; k++)
                    begin
                        outs[n] = char_of(6'(acc_bits >> (18 - 6 * k)));
                        n++;
                    end
                    acc_bits  = '0;
                    acc_count = 0;
                end
            end
            // partial group at message end: two or three chars, then pad
            if (last && acc_count != 0)
            begin
                outs[0] = char_of(acc_bits[23:18]);
                outs[1] = char_of(acc_bits[17:12]);
                outs[2] = (acc_count == 2) ? char_of(acc_bits[11:6]) : CHAR_PAD;
                outs[3] = CHAR_PAD;
                n = 4;
            end
        end
        else
        begin
            if (has && !dec_halted)
            begin
                s = sextet_of(b);
                if (s > 63)
                    dec_halted = 1'b1;
                else
                begin
                    acc_bits = acc_bits | (24'(s) << (18 - 6 * acc_count));
                    if (acc_count == 3)
                    begin
                        outs[0] = acc_bits[23:16];
                        outs[1] = acc_bits[15:8];
                        outs[2] = acc_bits[7:0];
                        n = 3;
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                    else
                        acc_count = acc_count + 1;
                end
            end
            // i pending sextets flush as i-1 bytes
            if (last)
                for (k = 0; k + 1 < acc_count; k++)
                begin
                    outs[n] = 8'(acc_bits >> (16 - 8 * k));
                    n++;
                end
        end
        if (last)
            clear_group();
        for (k = 0; k < n; k++)
        begin
            r.ch       = outs[k];
            r.step_end = (k == n - 1);
            r.msg_fin  = (k == n - 1) && last;
            awaited    = {awaited, r};
        end
    endfunction

    // ------------------------------------------------------------------
    // Script building
    // ------------------------------------------------------------------
    function automatic void push_item(input logic [7:0] b, input logic has,
                                      input logic last);
        script_step_t st;
        st.kind = STEP_ITEM;
        st.data = b;
        st.has  = has;
        st.last = last;
        st.mode = 1'b0;
        script  = {script, st};
        data_items++;
    endfunction

    function automatic void push_ctrl(input step_kind_t kind, input logic m);
        script_step_t st;
        st.kind = kind;
        st.data = 8'h00;
        st.has  = 1'b0;
        st.last = 1'b0;
        st.mode = m;
        script  = {script, st};
    endfunction

    // Sends a character or byte list as one message, sometimes with noise
    // items between, closed either on the last one or by a bare marker
    function automatic void push_message(input logic [7:0] txt[$]);
        logic bare;
        int   i;
        bare = (txt.size() == 0) || ($urandom_range(4) == 0);
        for (i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(9) == 0)
                push_item(8'($urandom_range(255)), 1'b0, 1'b0);
            push_item(txt[i], 1'b1, !bare && (i == txt.size() - 1));
        end
        if (bare)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endfunction

    function automatic void random_plain_message();
        logic [7:0] raw[$];
        int         len;
        int         i;
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(7);
        for (i = 0; i < len; i++)
            raw = {raw, 8'($urandom_range(255))};
        push_message(raw);
    endfunction

    // Mostly well-formed text, padded or not; otherwise a random mix of
    // alphabet characters, pads and arbitrary bytes
    function automatic void random_text_message();
        logic [7:0]  raw[$];
        logic [7:0]  txt[$];
        logic [23:0] w;
        logic        pad;
        int          len;
        int          i;
        int          j;
        int          nch;
        int          r;
        if ($urandom_range(9) < 7)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
            pad = ($urandom_range(3) != 0);
            for (i = 0; i < len; i++)
                raw = {raw, 8'($urandom_range(255))};
            raw = {raw, 8'h00};
            raw = {raw, 8'h00};
            for (i = 0; i < len; i += 3)
            begin
                w   = {raw[i], raw[i + 1], raw[i + 2]};
                nch = (len - i >= 3) ? 4 : len - i + 1;
                for (j = 0; j < nch; j++)
                    txt = {txt, char_of(6'(w >> (18 - 6 * j)))};
                if (pad)
                    for (j = nch; j < 4; j++)
                        txt = {txt, CHAR_PAD};
            end
        end
        else
        begin
            len = $urandom_range(10, 1);
            for (i = 0; i < len; i++)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    txt = {txt, char_of(6'($urandom_range(63)))};
                else if (r < 85)
                    txt = {txt, CHAR_PAD};
                else
                    txt = {txt, 8'($urandom_range(255))};
            end
        end
        push_message(txt);
    endfunction

    // ------------------------------------------------------------------
    // Driver: walks the script. Items go out on the input channel; mode
    // writes and drain points wait until the block has gone quiet.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : feeder
        script_step_t cur;
        logic         hold_in;
        logic         hold_cfg;
        int           nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_byte   <= 8'h00;
            has_data  <= 1'b0;
            msg_end   <= 1'b0;
            cfg_valid <= 1'b0;
            cfg_data  <= 1'b0;
            next_step <= 0;
            calm      <= 1'b0;
        end
        else
        begin
            hold_in  = in_valid && !in_ready;
            hold_cfg = cfg_valid && !cfg_ready;
            nxt      = next_step;
            if (!hold_in && !hold_cfg && nxt < script.size())
            begin
                cur = script[nxt];
                if (cur.kind == STEP_ITEM)
                begin
                    if (calm || $urandom_range(99) >= IDLE_PCT)
                    begin
                        hold_in = 1'b1;
                        in_byte  <= cur.data;
                        has_data <= cur.has;
                        msg_end  <= cur.last;
                        nxt++;
                    end
                end
                else if (!in_valid && quiet_cycles >= SETTLE_CYCLES)
                begin
                    if (cur.kind == STEP_MODE)
                    begin
                        hold_cfg = 1'b1;
                        cfg_data <= cur.mode;
                    end
                    nxt++;
                end
            end
            in_valid  <= hold_in;
            cfg_valid <= hold_cfg;
            next_step <= nxt;
            calm      <= (nxt >= CALM_FIRST) && (nxt < CALM_LAST);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, then updates the model with this edge's
    // mode write and item. Also tracks quiet and stalled cycles.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watcher
        codec_out_t want;
        logic       moved;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            quiet_cycles <= 0;
            stall_cycles <= 0;
            model_mode = MODE_ENCODE;
            clear_group();
            awaited.delete();
        end
        else
        begin
            moved = (in_valid && in_ready) || (out_valid && out_ready)
                    || (cfg_valid && cfg_ready);
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $error("out_byte: unexpected result %02h, nothing awaited",
                               out_byte);
                    mismatches++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        if (mismatches < REPORT_CAP)
                            $error("out_byte: expected %02h, got %02h", want.ch, out_byte);
                        mismatches++;
                    end
                    if (run_last !== want.step_end)
                    begin
                        if (mismatches < REPORT_CAP)
                            $error("run_last: expected %0b, got %0b",
                                   want.step_end, run_last);
                        mismatches++;
                    end
                    if (message_last !== want.msg_fin)
                    begin
                        if (mismatches < REPORT_CAP)
                            $error("message_last: expected %0b, got %0b",
                                   want.msg_fin, message_last);
                        mismatches++;
                    end
                end
            end
            // a mode write also drops any half-built group
            if (cfg_valid && cfg_ready)
            begin
                model_mode = cfg_data;
                clear_group();
            end
            if (in_valid && in_ready)
                codec_step(in_byte, has_data, msg_end);
            out_ready    <= calm || ($urandom_range(99) >= IDLE_PCT);
            quiet_cycles <= (moved || out_valid || awaited.size() != 0) ? 0
                            : quiet_cycles + 1;
            stall_cycles <= moved ? 0 : stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Script, reset and verdict
    // ------------------------------------------------------------------
    initial
    begin : scenario
        logic [7:0] none[$];
        logic       m;
        int         phase;
        int         msgs;
        int         j;

        // Encode: full group, one byte, empty message, two bytes closed by
        // a bare marker with noise between, full group on message end
        push_ctrl(STEP_MODE, MODE_ENCODE);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'h5A, 1'b0, 1'b1);
        push_item(8'h12, 1'b1, 1'b0);
        push_item(8'hA5, 1'b0, 1'b0);
        push_item(8'h34, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item("M", 1'b1, 1'b0);
        push_item("a", 1'b1, 1'b0);
        push_item("n", 1'b1, 1'b1);
        // left pending; the mode write must discard it
        push_item(8'h01, 1'b1, 1'b0);

        // Decode: slash, plus, a digit, a letter; padded pair; lone char gives
        // nothing; a top-bit byte stops decoding, later chars ignored
        push_ctrl(STEP_MODE, MODE_DECODE);
        push_item(CHAR_SLASH, 1'b1, 1'b0);
        push_item(CHAR_PLUS, 1'b1, 1'b0);
        push_item("9", 1'b1, 1'b0);
        push_item("z", 1'b1, 1'b1);
        push_item("T", 1'b1, 1'b0);
        push_item("Q", 1'b1, 1'b0);
        push_item(CHAR_PAD, 1'b1, 1'b0);
        push_item(CHAR_PAD, 1'b1, 1'b1);
        push_item("Q", 1'b1, 1'b1);
        push_item("Z", 1'b1, 1'b0);
        push_item("m", 1'b1, 1'b0);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item("9", 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);

        // Random phases, each behind a mode write; mostly alternating
        m     = MODE_DECODE;
        phase = 0;
        while (data_items < TARGET_ITEMS)
        begin
            if (phase > 0 && $urandom_range(5) == 0)
                push_item(8'($urandom_range(255)), 1'b1, 1'b0);
            m = ($urandom_range(4) == 0) ? m : !m;
            push_ctrl(STEP_MODE, m);
            msgs = $urandom_range(10, 4);
            for (j = 0; j < msgs; j++)
            begin
                // hold the sender back once until all output has drained
                if (phase == 1 && j == 2)
                    push_ctrl(STEP_DRAIN, 1'b0);
                if (m == MODE_ENCODE)
                    random_plain_message();
                else
                    random_text_message();
            end
            phase++;
        end
        push_message(none);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (!(next_step == script.size() && !in_valid && !cfg_valid
                 && quiet_cycles >= END_SETTLE) && stall_cycles < STALL_LIMIT)
            @(posedge clk);

        if (stall_cycles >= STALL_LIMIT)
            $error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        if (stall_cycles >= STALL_LIMIT || mismatches != 0)
            $display("tb_top NOT OK");
        else
            $display("tb_top OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/b64_pkg.sv
sv/b64_group.sv
sv/b64_emit.sv
sv/base64_stream_codec.sv
bench/tb_top.sv
